FILE: rtl/skw_pkg.sv
// Package of constants, types and the exponential table for the weight similarity block.
`timescale 1ns / 1ps
`default_nettype none
package skw_pkg;

    localparam int MAX_INFLUENCES  = 8;
    localparam int BONE_INDEX_BITS = 8;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int LIST_COUNT   = 4;
    localparam int INV_SIGMA2   = 100;
    localparam int SERIES_TERMS = 48;
    localparam int BONE_W       = (BONE_INDEX_BITS < 8) ? BONE_INDEX_BITS : 8;
    localparam int IDX_W        = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
    localparam int CNT_W        = $clog2(MAX_INFLUENCES + 1);
    localparam int EXP_IDX_W    = $clog2(EXP_TABLE_DEPTH);
    localparam int MUL_W        = 32;

    // Reciprocal of three for sums below 2^17: floor(x * 43691 / 2^17) = floor(x / 3).
    localparam logic [15:0] RECIP3   = 16'd43691;
    localparam logic [15:0] Q15_ONE  = 16'd32768;

    typedef logic [15:0] exp_table_t [EXP_TABLE_DEPTH];

    // Unsigned quotient by restoring long division, only evaluated while the table is built.
    function automatic logic [127:0] div_u128(input logic [127:0] num,
                                              input logic [127:0] den);
        logic [127:0] q;
        logic [128:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[127:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table of exp(-100*i/depth) in Q1.15, built by a series and repeated multiplication.
    function automatic exp_table_t build_exp_table();
        logic [127:0] term;
        logic [127:0] e;
        logic [127:0] r;
        logic [127:0] acc;
        exp_table_t   t;
        term = 128'd1 << 32;
        e    = 128'd0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            if (n > 0) begin
                term = div_u128(term * 128'(INV_SIGMA2), 128'(EXP_TABLE_DEPTH * n));
            end
            e = e + term;
        end
        r   = div_u128({64'd0, {64{1'b1}}}, e);
        acc = 128'd1 << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            if (i > 0) begin
                acc = (acc * r) >> 32;
            end
            t[i] = 16'((acc + (128'd1 << 16)) >> 17);
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

FILE: rtl/skw_mul.sv
// Shared registered multiplier used by the similarity sequencer.
`timescale 1ns / 1ps
`default_nettype none
module skw_mul (
    input  wire logic                          clk,
    input  wire logic [skw_pkg::MUL_W-1:0]     a,
    input  wire logic [skw_pkg::MUL_W-1:0]     b,
    output logic      [2*skw_pkg::MUL_W-1:0]   p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule
`default_nettype wire

FILE: rtl/skin_weight_similarity_top.sv
// Top level of the skinning weight similarity block: list store, sequencer and accumulator.
// A transfer with last set starts the computation. Matching steps through each vertex entry,
// scanning the corner entries and then averaging the corners; the pair sum steps through
// each kept entry and each ordered pair, all through the one shared multiplier.
// busy is high until the result strobe; results cannot be stalled by the receiver.
// Reset clears the list counts, the overflow flag and the sequencer; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module skin_weight_similarity_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  bone,
    input  wire logic [15:0] weight,
    input  wire logic        last,
    output logic             valid,
    output logic [31:0]      similarity,
    output logic             overflow
);

    localparam int MAXI  = skw_pkg::MAX_INFLUENCES;
    localparam int IW    = skw_pkg::IDX_W;
    localparam int CW    = skw_pkg::CNT_W;
    localparam int MW    = skw_pkg::MUL_W;
    localparam int XW    = skw_pkg::EXP_IDX_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_VSTART = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_AVG    = 4'd3;
    localparam logic [3:0] S_JSTART = 4'd4;
    localparam logic [3:0] S_JPROD  = 4'd5;
    localparam logic [3:0] S_KSTART = 4'd6;
    localparam logic [3:0] S_Y      = 4'd7;
    localparam logic [3:0] S_D      = 4'd8;
    localparam logic [3:0] S_IDX    = 4'd9;
    localparam logic [3:0] S_CLAMP  = 4'd10;
    localparam logic [3:0] S_PK     = 4'd11;
    localparam logic [3:0] S_TERM   = 4'd12;
    localparam logic [3:0] S_ACC    = 4'd13;

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg [skw_pkg::LIST_COUNT];
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [1:0]    c_reg, c_next;
    logic [CW-1:0] e_reg, e_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          sat_reg, sat_next;
    logic          valid_reg, valid_next;

    // Payload state.
    logic [skw_pkg::BONE_W-1:0] bones_reg   [skw_pkg::LIST_COUNT][MAXI];
    logic [15:0]                weights_reg [skw_pkg::LIST_COUNT][MAXI];
    logic [15:0]                wv_reg [MAXI];
    logic [15:0]                tv_reg [MAXI];
    logic [skw_pkg::BONE_W-1:0] vb_reg;
    logic [15:0]                vw_reg;
    logic [16:0]                sum_reg, sum_next;
    logic [15:0]                wj_reg, tj_reg, wk_reg, tk_reg;
    logic [MW-1:0]              pj_reg, x_reg;
    logic [XW-1:0]              idx_reg;
    logic [31:0]                acc_reg, acc_next;
    logic [31:0]                sim_reg;
    logic                       oflag_reg;

    logic          accept;
    logic [15:0]   w_clamped;
    logic          do_store;
    logic [1:0]    rd_list;
    logic [CW-1:0] rd_entry;
    logic [skw_pkg::BONE_W-1:0] rd_bone;
    logic [15:0]   rd_weight;
    logic [CW-1:0] pr_addr;
    logic [15:0]   pr_w, pr_t;
    logic [MW-1:0] mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic [MW-1:0] d_abs;
    logic [32:0]   avg_prod;
    logic [15:0]   avg;
    logic [47:0]   acc_sum;

    assign accept    = start && (state_reg == S_IDLE);
    assign w_clamped = (weight > skw_pkg::Q15_ONE) ? skw_pkg::Q15_ONE : weight;
    assign do_store  = accept && (w_clamped != 16'd0) && (cnt_reg[command] != CW'(MAXI));

    // One read port into the list store: the vertex entry or the corner entry being scanned.
    assign rd_list   = (state_reg == S_VSTART) ? 2'd0 : c_reg;
    assign rd_entry  = (state_reg == S_VSTART) ? i_reg : e_reg;
    assign rd_bone   = bones_reg[rd_list][rd_entry[IW-1:0]];
    assign rd_weight = weights_reg[rd_list][rd_entry[IW-1:0]];

    // One read port into the kept pairs.
    assign pr_addr = (state_reg == S_JSTART) ? j_reg : k_reg;
    assign pr_w    = wv_reg[pr_addr[IW-1:0]];
    assign pr_t    = tv_reg[pr_addr[IW-1:0]];

    // Rounded average over three corners.
    assign avg_prod = 33'(sum_reg + 17'd1) * 33'(skw_pkg::RECIP3);
    assign avg      = avg_prod[32:17];

    assign d_abs   = (x_reg > mul_p[MW-1:0]) ? (x_reg - mul_p[MW-1:0]) : (mul_p[MW-1:0] - x_reg);
    assign acc_sum = {16'd0, acc_reg} + {1'b0, mul_p[2*MW-1:17]};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_JSTART:
            begin
                mul_a = MW'(pr_w);
                mul_b = MW'(pr_t);
            end
            S_KSTART:
            begin
                mul_a = MW'(wj_reg);
                mul_b = MW'(pr_t);
            end
            S_Y:
            begin
                mul_a = MW'(wk_reg);
                mul_b = MW'(tj_reg);
            end
            S_D:
            begin
                mul_a = d_abs;
                mul_b = d_abs;
            end
            S_IDX:
            begin
                mul_a = mul_p[61:30];
                mul_b = MW'(skw_pkg::EXP_TABLE_DEPTH);
            end
            S_CLAMP:
            begin
                mul_a = MW'(wk_reg);
                mul_b = MW'(tk_reg);
            end
            S_PK:
            begin
                mul_a = pj_reg;
                mul_b = mul_p[MW-1:0];
            end
            S_TERM:
            begin
                mul_a = mul_p[61:30];
                mul_b = MW'(skw_pkg::EXP_TABLE[idx_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    skw_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        kept_next  = kept_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        sat_next   = sat_reg;
        acc_next   = acc_reg;
        sum_next   = sum_reg;
        valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((w_clamped != 16'd0) && (cnt_reg[command] == CW'(MAXI)))
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = S_VSTART;
                        i_next     = '0;
                        kept_next  = '0;
                    end
                end
            end
            S_VSTART:
            begin
                if (i_reg == cnt_reg[0])
                begin
                    state_next = S_JSTART;
                    j_next     = '0;
                    acc_next   = '0;
                    sat_next   = 1'b0;
                end
                else
                begin
                    state_next = S_SCAN;
                    c_next     = 2'd1;
                    e_next     = '0;
                    sum_next   = '0;
                end
            end
            S_SCAN:
            begin
                // A corner ends at its count or at its first equal bone.
                if ((e_reg == cnt_reg[c_reg]) || (rd_bone == vb_reg))
                begin
                    if ((e_reg != cnt_reg[c_reg]) && (rd_bone == vb_reg))
                    begin
                        sum_next = sum_reg + 17'(rd_weight);
                    end
                    e_next = '0;
                    if (c_reg == 2'd3)
                    begin
                        state_next = S_AVG;
                    end
                    else
                    begin
                        c_next = c_reg + 2'd1;
                    end
                end
                else
                begin
                    e_next = e_reg + CW'(1);
                end
            end
            S_AVG:
            begin
                if (avg != 16'd0)
                begin
                    kept_next = kept_reg + CW'(1);
                end
                i_next     = i_reg + CW'(1);
                state_next = S_VSTART;
            end
            S_JSTART:
            begin
                if (j_reg == kept_reg)
                begin
                    state_next = S_IDLE;
                    valid_next = 1'b1;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    state_next = S_JPROD;
                end
            end
            S_JPROD:
            begin
                k_next     = '0;
                state_next = S_KSTART;
            end
            S_KSTART:
            begin
                if (k_reg == kept_reg)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_JSTART;
                end
                else if (k_reg == j_reg)
                begin
                    k_next = k_reg + CW'(1);
                end
                else
                begin
                    state_next = S_Y;
                end
            end
            S_Y:     state_next = S_D;
            S_D:     state_next = S_IDX;
            S_IDX:   state_next = S_CLAMP;
            S_CLAMP: state_next = S_PK;
            S_PK:    state_next = S_TERM;
            S_TERM:  state_next = S_ACC;
            S_ACC:
            begin
                if (acc_sum > 48'hFFFF_FFFF)
                begin
                    acc_next = 32'hFFFF_FFFF;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_sum[31:0];
                end
                k_next     = k_reg + CW'(1);
                state_next = S_KSTART;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            c_reg     <= '0;
            e_reg     <= '0;
            kept_reg  <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sat_reg   <= 1'b0;
            valid_reg <= 1'b0;
            for (int l = 0; l < skw_pkg::LIST_COUNT; l++)
            begin
                cnt_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            c_reg     <= c_next;
            e_reg     <= e_next;
            kept_reg  <= kept_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sat_reg   <= sat_next;
            valid_reg <= valid_next;
            if (do_store)
            begin
                cnt_reg[command] <= cnt_reg[command] + CW'(1);
            end
            // All lists empty again once the result goes out.
            if (valid_next)
            begin
                for (int l = 0; l < skw_pkg::LIST_COUNT; l++)
                begin
                    cnt_reg[l] <= '0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            bones_reg[command][cnt_reg[command][IW-1:0]]   <= bone[skw_pkg::BONE_W-1:0];
            weights_reg[command][cnt_reg[command][IW-1:0]] <= w_clamped;
        end
        sum_reg <= sum_next;
        acc_reg <= acc_next;
        if ((state_reg == S_VSTART) && (i_reg != cnt_reg[0]))
        begin
            vb_reg <= rd_bone;
            vw_reg <= rd_weight;
        end
        if ((state_reg == S_AVG) && (avg != 16'd0))
        begin
            wv_reg[kept_reg[IW-1:0]] <= vw_reg;
            tv_reg[kept_reg[IW-1:0]] <= avg;
        end
        if (state_reg == S_JSTART)
        begin
            wj_reg <= pr_w;
            tj_reg <= pr_t;
        end
        if (state_reg == S_JPROD)
        begin
            pj_reg <= mul_p[MW-1:0];
        end
        if (state_reg == S_KSTART)
        begin
            wk_reg <= pr_w;
            tk_reg <= pr_t;
        end
        if (state_reg == S_Y)
        begin
            x_reg <= mul_p[MW-1:0];
        end
        if (state_reg == S_CLAMP)
        begin
            if (mul_p[2*MW-1:30] >= 34'(skw_pkg::EXP_TABLE_DEPTH))
            begin
                idx_reg <= XW'(skw_pkg::EXP_TABLE_DEPTH - 1);
            end
            else
            begin
                idx_reg <= mul_p[30 +: XW];
            end
        end
        if (valid_next)
        begin
            sim_reg   <= acc_reg;
            oflag_reg <= sat_reg | ovf_reg;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign valid      = valid_reg;
    assign similarity = sim_reg;
    assign overflow   = oflag_reg;

endmodule
`default_nettype wire

FILE: tb/skw_checker.sv
// Checker that predicts the similarity results from accepted transfers and compares them.
`timescale 1ns / 1ps
`default_nettype none
module skw_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  bone,
    input  wire logic [15:0] weight,
    input  wire logic        last,
    input  wire logic        valid,
    input  wire logic [31:0] similarity,
    input  wire logic        overflow,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] sim;
        logic        ovf;
    } sim_result_t;

    logic [7:0]  list_bone   [skw_pkg::LIST_COUNT][skw_pkg::MAX_INFLUENCES];
    logic [15:0] list_weight [skw_pkg::LIST_COUNT][skw_pkg::MAX_INFLUENCES];
    int          list_fill   [skw_pkg::LIST_COUNT];
    logic        dropped;
    sim_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic sim_result_t similarity_of_set();
        logic [63:0] wv [skw_pkg::MAX_INFLUENCES];
        logic [63:0] tv [skw_pkg::MAX_INFLUENCES];
        logic [63:0] x, y, d, idx, term, acc;
        logic [31:0] sum;
        int          kept;
        sim_result_t r;
        kept = 0;
        acc = 0;
        r.ovf = 0;
        for (int i = 0; i < list_fill[0]; i++) begin
            sum = 0;
            for (int c = 1; c < skw_pkg::LIST_COUNT; c++) begin
                for (int e = 0; e < list_fill[c]; e++) begin
                    if (list_bone[c][e] == list_bone[0][i]) begin
                        sum += list_weight[c][e];
                        break;
                    end
                end
            end
            sum = (sum + 1) / 3;
            if (sum != 0) begin
                wv[kept] = list_weight[0][i];
                tv[kept] = sum;
                kept++;
            end
        end
        for (int j = 0; j < kept; j++) begin
            for (int k = 0; k < kept; k++) begin
                if (k != j) begin
                    x = wv[j] * tv[k];
                    y = wv[k] * tv[j];
                    d = (x > y) ? x - y : y - x;
                    idx = (((d * d) >> 30) * skw_pkg::EXP_TABLE_DEPTH) >> 30;
                    if (idx >= skw_pkg::EXP_TABLE_DEPTH) idx = skw_pkg::EXP_TABLE_DEPTH - 1;
                    term = ((((wv[j] * tv[j]) * (wv[k] * tv[k])) >> 30)
                            * skw_pkg::EXP_TABLE[idx]) >> 17;
                    acc += term;
                    if (acc > 64'hFFFF_FFFF) begin
                        acc = 64'hFFFF_FFFF;
                        r.ovf = 1;
                    end
                end
            end
        end
        r.sim = acc[31:0];
        r.ovf = r.ovf | dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] w;
        sim_result_t got, want;
        if (!rst_n)
        begin
            for (int c = 0; c < skw_pkg::LIST_COUNT; c++) list_fill[c] = 0;
            dropped = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // Results are checked before this edge's transfer can queue a new one.
            if (valid)
            begin
                got.sim = similarity;
                got.ovf = overflow;
                if (expected_results.size() == 0)
                begin
                    $error("Result strobe with no result expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sim !== want.sim)
                    begin
                        $error("similarity: expected %h, actual %h", want.sim, got.sim);
                        fail_count++;
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $error("overflow: expected %b, actual %b", want.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                w = (weight > skw_pkg::Q15_ONE) ? skw_pkg::Q15_ONE : weight;
                if (w != 0)
                begin
                    if (list_fill[command] < skw_pkg::MAX_INFLUENCES)
                    begin
                        list_bone[command][list_fill[command]] = bone;
                        list_weight[command][list_fill[command]] = w;
                        list_fill[command]++;
                    end
                    else
                    begin
                        dropped = 1;
                    end
                end
                if (last)
                begin
                    expected_results = {expected_results, similarity_of_set()};
                    for (int c = 0; c < skw_pkg::LIST_COUNT; c++) list_fill[c] = 0;
                    dropped = 0;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench top: drives weight-list transfers into the similarity block and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    // Well above a run in which every transfer closes a full set after the longest gap.
    localparam int CYCLE_LIMIT = 5_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [7:0]  bone;
    logic [15:0] weight;
    logic        last;
    logic        valid;
    logic [31:0] similarity;
    logic        overflow;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    skin_weight_similarity_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .bone(bone), .weight(weight), .last(last),
        .valid(valid), .similarity(similarity), .overflow(overflow)
    );

    skw_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .bone(bone), .weight(weight), .last(last),
        .valid(valid), .similarity(similarity), .overflow(overflow),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // The watchdog ends the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, and often none at all.
    // start is only dropped when there really is a gap.
    task automatic idle_gap();
        int n;
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: n = 0;
                9:          n = $urandom_range(10, 40);
                default:    n = $urandom_range(1, 3);
            endcase
            if (n > 0)
            begin
                start <= 0;
                repeat (n) @(negedge clk);
            end
        end
    endtask

    // One transfer: the fields are set up at the falling edge and held until accepted.
    // start stays high across back-to-back transfers, so it is never dropped and raised in one step.
    task automatic send_entry(input logic [1:0] c, input logic [7:0] b,
                              input logic [15:0] w, input logic l, input bit gap);
        begin
            if (gap)
            begin
                idle_gap();
            end
            start   <= 1;
            command <= c;
            bone    <= b;
            weight  <= w;
            last    <= l;
            @(posedge clk);
            while (busy) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic wait_results_drained();
        begin
            start <= 0;
            @(negedge clk);
            while (pending != 0) @(negedge clk);
        end
    endtask

    // A random set: bones drawn from a pool that is usually small but sometimes all 256 values; a list may overflow.
    // Weights lean towards large values so that products and saturation are reached.
    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(32769, 65535));
            2:       return skw_pkg::Q15_ONE;
            3, 4:    return 16'($urandom_range(1, 2000));
            default: return 16'($urandom_range(16000, 32768));
        endcase
    endfunction

    task automatic send_random_set();
        int          counts [4];
        int          total;
        int          sent;
        int          pool;
        logic [1:0]  c;
        begin
            pool = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 12);
            total = 0;
            for (int i = 0; i < 4; i++)
            begin
                counts[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 11)
                                                         : $urandom_range(0, 8);
                total += counts[i];
            end
            if (total == 0)
            begin
                counts[0] = 1;
                total = 1;
            end
            sent = 0;
            // Lists are interleaved at random; the last entry closes the set.
            while (sent < total)
            begin
                do c = 2'($urandom_range(0, 3)); while (counts[c] == 0);
                counts[c]--;
                sent++;
                send_entry(c, 8'($urandom_range(0, pool - 1)), pick_weight(),
                           sent == total, 1);
            end
        end
    endtask

    initial
    begin
        start = 0;
        command = 0;
        bone = 0;
        weight = 0;
        last = 0;
        rst_n = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: empty set closed by a zero weight.
        send_entry(2'd0, 8'd0, 16'd0, 1, 0);
        // One pair matched with full weights in every corner, bone 255, over-range weight clamped.
        send_entry(2'd0, 8'd255, 16'hFFFF, 0, 0);
        send_entry(2'd0, 8'd0, 16'd1, 0, 0);
        send_entry(2'd1, 8'd255, skw_pkg::Q15_ONE, 0, 0);
        send_entry(2'd2, 8'd255, 16'h8001, 0, 0);
        send_entry(2'd3, 8'd0, 16'd1, 0, 0);
        send_entry(2'd3, 8'd255, skw_pkg::Q15_ONE, 0, 0);
        send_entry(2'd1, 8'd0, 16'd2, 1, 0);
        // Overflowing vertex list with duplicate bones, then two sets of a single corner entry each.
        for (int i = 0; i < 9; i++)
            send_entry(2'd0, 8'd7, skw_pkg::Q15_ONE, 0, 0);
        send_entry(2'd1, 8'd7, skw_pkg::Q15_ONE, 0, 0);
        send_entry(2'd1, 8'd7, 16'd5, 1, 0);
        send_entry(2'd2, 8'd170, 16'h5555, 1, 0);
        send_entry(2'd3, 8'd85, 16'hAAAA, 1, 0);
        // Pause until the block has answered everything so far.
        wait_results_drained();

        for (int n = 0; n < 88; n++)
        begin
            send_random_set();
            if (n == 44) wait_results_drained();
        end
        wait_results_drained();
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/skw_pkg.sv
rtl/skw_mul.sv
rtl/skin_weight_similarity_top.sv
tb/skw_checker.sv
tb/tb.sv
